>>> hw/rtl/rgbseq_pkg.sv
package rgbseq_pkg;

	// Field and state widths.
	localparam int unsigned TIMER_W   = 25;
	localparam int unsigned COLOR_W   = 8;
	localparam int unsigned ALPHA_W   = 8;
	localparam int unsigned HOLD_W    = 24;
	localparam int unsigned SHIFT_W   = 3;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = HOLD_W;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_SHIFT  = 2'd2;

	// Reset values.
	localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST  = 24'd117640;
	localparam logic [SHIFT_W-1:0] BLINK_SHIFT_RST = 3'd3;
	localparam logic [SHIFT_W-1:0] FADE_SHIFT_RST  = 3'd4;
	localparam logic [COLOR_W-1:0] COLOR_RST       = 8'd100;

	// Brightness constants.
	localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'hFF;
	localparam logic [ALPHA_W-1:0] ALPHA_DARK  = 8'h00;
	localparam logic [TIMER_W-1:0] BLINK_PEAK  = 25'd256;
	localparam logic [TIMER_W-1:0] BLINK_WRAP  = 25'd511;
	localparam logic [TIMER_W:0]   FADE_STEPS  = 26'd255;

	typedef enum logic [MODE_W-1:0] {
		MODE_CONST     = 2'd0,
		MODE_BLINK     = 2'd1,
		MODE_TIMEOUT   = 2'd2,
		MODE_CONST_ALT = 2'd3
	} mode_t;

	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_LOAD = 1'b1
	} func_t;

	// Live configuration register values.
	typedef struct packed {
		logic [HOLD_W-1:0]  hold_ticks;
		logic [SHIFT_W-1:0] blink_shift;
		logic [SHIFT_W-1:0] fade_shift;
	} cfg_t;

	// One input word as held in the input register.
	typedef struct packed {
		func_t              func;
		logic               led_select;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		mode_t              mode;
	} item_t;

	// Alpha and raw colour of the LED served by a tick.
	typedef struct packed {
		logic               led;
		logic [ALPHA_W-1:0] alpha;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} tick_res_t;

endpackage

>>> hw/rtl/rgbseq_item_if.sv
interface rgbseq_item_if;
	import rgbseq_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic               led_select;
	logic [COLOR_W-1:0] red_in;
	logic [COLOR_W-1:0] green_in;
	logic [COLOR_W-1:0] blue_in;
	logic [MODE_W-1:0]  mode_in;

	modport source (
		output valid, func, led_select, red_in, green_in, blue_in, mode_in,
		input  ready
	);
	modport sink (
		input  valid, func, led_select, red_in, green_in, blue_in, mode_in,
		output ready
	);
endinterface

>>> hw/rtl/rgbseq_result_if.sv
interface rgbseq_result_if;
	import rgbseq_pkg::*;

	logic               valid;
	logic               ready;
	logic               led_served;
	logic [ALPHA_W-1:0] alpha_out;
	logic [COLOR_W-1:0] red_drive;
	logic [COLOR_W-1:0] green_drive;
	logic [COLOR_W-1:0] blue_drive;

	modport source (
		output valid, led_served, alpha_out, red_drive, green_drive, blue_drive,
		input  ready
	);
	modport sink (
		input  valid, led_served, alpha_out, red_drive, green_drive, blue_drive,
		output ready
	);
endinterface

>>> hw/rtl/rgbseq_cfg_if.sv
interface rgbseq_cfg_if;
	import rgbseq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

>>> hw/rtl/rgb_led_blink_fade_sequencer_unit.sv
// Brightness sequencer for NUM_LEDS RGB LEDs. A load word (func 1) sets one LED's
// colour and mode (constant, blink, timeout) and produces no result; a tick word
// (func 0) serves the next LED in turn, starting with LED 1, and produces one result
// word with that LED's alpha and its colour scaled as value*alpha>>8. The block takes
// one word per clock while input ready is high: each word passes an input register, the
// timer update and scaling logic, and the output register, so a tick's result is
// registered in the output register as the tick leaves the input register and is offered
// until taken, and a load affects any word accepted after it. Input ready drops only
// while a tick waits in the input register behind an output word that has not been taken.
// Configuration registers (hold_ticks, blink_shift, fade_shift)
// are always ready and are to be written only while no word is in flight.
module rgb_led_blink_fade_sequencer_unit
	import rgbseq_pkg::*;
#(
	parameter int NUM_LEDS = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	rgbseq_item_if.sink     item,
	rgbseq_result_if.source result,
	rgbseq_cfg_if.sink      cfg
);

	logic      s1_valid_q;
	item_t     item_s1;
	logic      out_free;
	logic      s1_fire;
	logic      tick_take;
	logic      in_accept;
	cfg_t      cfg_q;
	tick_res_t tick_res;

	// Handshake: a load always leaves the input register, a tick needs output room.
	assign out_free   = !result.valid || result.ready;
	assign s1_fire    = s1_valid_q && (item_s1.func == FUNC_LOAD || out_free);
	assign tick_take  = s1_fire && (item_s1.func == FUNC_TICK);
	assign item.ready = !s1_valid_q || s1_fire;
	assign in_accept  = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.func       <= func_t'(item.func);
			item_s1.led_select <= item.led_select;
			item_s1.red        <= item.red_in;
			item_s1.green      <= item.green_in;
			item_s1.blue       <= item.blue_in;
			item_s1.mode       <= mode_t'(item.mode_in);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks  <= HOLD_TICKS_RST;
			cfg_q.blink_shift <= BLINK_SHIFT_RST;
			cfg_q.fade_shift  <= FADE_SHIFT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_HOLD_TICKS:  cfg_q.hold_ticks  <= cfg.data;
				REG_BLINK_SHIFT: cfg_q.blink_shift <= cfg.data[SHIFT_W-1:0];
				REG_FADE_SHIFT:  cfg_q.fade_shift  <= cfg.data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	rgbseq_led_core #(
		.NUM_LEDS(NUM_LEDS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.fire   (s1_fire),
		.word   (item_s1),
		.res    (tick_res)
	);

	rgbseq_drive_stage u_drive (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (tick_take),
		.res_in (tick_res),
		.result (result)
	);

`ifndef SYNTH
	// A result word only appears after a tick left the input register.
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(tick_take))
		else $error("result word appeared without a tick");

	// Input backpressure only comes from a tick blocked by a full output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (s1_valid_q && item_s1.func == FUNC_TICK &&
		                 result.valid && !result.ready))
		else $error("input stalled without a blocked tick");
`endif

endmodule

>>> hw/rtl/rgbseq_led_core.sv
module rgbseq_led_core
	import rgbseq_pkg::*;
#(
	parameter int NUM_LEDS = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      fire,
	input  item_t     word,
	output tick_res_t res
);

	localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	// With a single LED the second select code addresses nothing.
	localparam bit SEL1_OK = (NUM_LEDS > 1);

	logic [IDX_W-1:0]   turn_q;
	logic [TIMER_W-1:0] timer_q [NUM_LEDS];
	mode_t              mode_q  [NUM_LEDS];
	logic [COLOR_W-1:0] red_q   [NUM_LEDS];
	logic [COLOR_W-1:0] green_q [NUM_LEDS];
	logic [COLOR_W-1:0] blue_q  [NUM_LEDS];

	logic [IDX_W-1:0]   turn_nxt;
	logic [IDX_W-1:0]   sel_idx;
	logic               sel_ok;
	logic [TIMER_W-1:0] cur_timer;
	logic [TIMER_W-1:0] t_inc;
	logic [TIMER_W-1:0] blink_sh;
	logic [TIMER_W:0]   fade_end;
	logic [TIMER_W-1:0] fade_pos;
	logic [TIMER_W-1:0] fade_sh;
	logic [TIMER_W-1:0] timer_nxt;
	logic [ALPHA_W-1:0] alpha;

	// The turn advances before use, so with two or more LEDs the first tick serves LED 1.
	assign turn_nxt  = (turn_q == IDX_W'(NUM_LEDS - 1)) ? '0 : turn_q + 1'b1;
	assign cur_timer = timer_q[turn_nxt];
	assign t_inc     = cur_timer + 1'b1;

	// Blink ramp: triangle wave on the shifted timer.
	assign blink_sh = t_inc >> cfg.blink_shift;

	// Timeout: hold, then a linear fade, then dark.
	assign fade_end = {2'b00, cfg.hold_ticks} + (FADE_STEPS << cfg.fade_shift);
	assign fade_pos = t_inc - TIMER_W'(cfg.hold_ticks);
	assign fade_sh  = fade_pos >> cfg.fade_shift;

	// Alpha and the timer value written back for the served LED.
	always_comb begin
		alpha     = ALPHA_FULL;
		timer_nxt = cur_timer;
		case (mode_q[turn_nxt])
			MODE_BLINK: begin
				alpha     = (blink_sh < BLINK_PEAK) ? blink_sh[ALPHA_W-1:0]
				                                    : ~blink_sh[ALPHA_W-1:0];
				timer_nxt = (blink_sh >= BLINK_WRAP) ? '0 : t_inc;
			end
			MODE_TIMEOUT: begin
				if (cur_timer < TIMER_W'(cfg.hold_ticks)) begin
					alpha     = ALPHA_FULL;
					timer_nxt = t_inc;
				end else if ({1'b0, cur_timer} < fade_end) begin
					alpha     = ~fade_sh[ALPHA_W-1:0];
					timer_nxt = t_inc;
				end else begin
					alpha     = ALPHA_DARK;
				end
			end
			default: begin
				alpha     = ALPHA_FULL;
				timer_nxt = cur_timer;
			end
		endcase
	end

	assign res.led   = turn_nxt[0];
	assign res.alpha = alpha;
	assign res.red   = red_q[turn_nxt];
	assign res.green = green_q[turn_nxt];
	assign res.blue  = blue_q[turn_nxt];

	assign sel_idx = IDX_W'(word.led_select);
	assign sel_ok  = !word.led_select || SEL1_OK;

	// Per-LED state: loads write colour and mode, ticks advance the turn and write back the timer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_q <= '0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				timer_q[i] <= '0;
				mode_q[i]  <= MODE_TIMEOUT;
				red_q[i]   <= COLOR_RST;
				green_q[i] <= COLOR_RST;
				blue_q[i]  <= COLOR_RST;
			end
		end else if (fire) begin
			if (word.func == FUNC_LOAD) begin
				if (sel_ok) begin
					red_q[sel_idx]   <= word.red;
					green_q[sel_idx] <= word.green;
					blue_q[sel_idx]  <= word.blue;
					mode_q[sel_idx]  <= word.mode;
					// Rewriting blink as blink keeps the running phase.
					if (!(mode_q[sel_idx] == MODE_BLINK && word.mode == MODE_BLINK)) begin
						timer_q[sel_idx] <= '0;
					end
				end
			end else begin
				turn_q            <= turn_nxt;
				timer_q[turn_nxt] <= timer_nxt;
			end
		end
	end

endmodule

>>> hw/rtl/rgbseq_drive_stage.sv
module rgbseq_drive_stage
	import rgbseq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  tick_res_t              res_in,
	rgbseq_result_if.source        result
);

	logic [2*COLOR_W-1:0] red_prod;
	logic [2*COLOR_W-1:0] green_prod;
	logic [2*COLOR_W-1:0] blue_prod;
	logic                 valid_q;

	// Colour times alpha; the drive value is the upper byte.
	assign red_prod   = res_in.red   * res_in.alpha;
	assign green_prod = res_in.green * res_in.alpha;
	assign blue_prod  = res_in.blue  * res_in.alpha;

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (take) begin
			result.led_served  <= res_in.led;
			result.alpha_out   <= res_in.alpha;
			result.red_drive   <= red_prod[2*COLOR_W-1:COLOR_W];
			result.green_drive <= green_prod[2*COLOR_W-1:COLOR_W];
			result.blue_drive  <= blue_prod[2*COLOR_W-1:COLOR_W];
		end
	end

	assign result.valid = valid_q;

endmodule

>>> sim/rgb_led_blink_fade_sequencer_unit_tb.sv
module rgb_led_blink_fade_sequencer_unit_tb;
	import rgbseq_pkg::*;

	localparam int LED_COUNT       = 2;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int TAIL_CYCLES     = 4;
	localparam int DRAIN_LIMIT     = 2000;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_PER_PHASE = 40;

	// Expected drive word for one tick.
	typedef struct packed {
		logic               led;
		logic [ALPHA_W-1:0] alpha;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n;

	rgbseq_item_if   item_bus ();
	rgbseq_result_if result_bus ();
	rgbseq_cfg_if    cfg_bus ();

	rgb_led_blink_fade_sequencer_unit #(
		.NUM_LEDS(LED_COUNT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the sequencer state and its settings.
	logic [TIMER_W-1:0] lamp_timer [LED_COUNT];
	mode_t              lamp_mode  [LED_COUNT];
	logic [COLOR_W-1:0] lamp_red   [LED_COUNT];
	logic [COLOR_W-1:0] lamp_green [LED_COUNT];
	logic [COLOR_W-1:0] lamp_blue  [LED_COUNT];
	logic               serve_turn;
	logic [HOLD_W-1:0]  cfg_hold;
	logic [SHIFT_W-1:0] cfg_blink;
	logic [SHIFT_W-1:0] cfg_fade;

	drive_t expected_drives [$];
	drive_t due_drive;
	int     fail_count = 0;
	int     cycle_count;
	int     src_idle_pct = 0;
	int     sink_stall_pct = 0;
	logic   hold_off_go = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Triangle wave: ramp up, ramp down with 8-bit wrap, restart at the top.
	function automatic logic [ALPHA_W-1:0] blink_step(input logic n);
		logic [TIMER_W-1:0] t;
		logic [31:0]        ramp;
		logic [31:0]        level;
		t = lamp_timer[n] + 1'b1;
		ramp = 32'(t) >> cfg_blink;
		if (32'(t) < (32'(BLINK_PEAK) << cfg_blink))
			level = ramp;
		else
			level = 32'(ALPHA_FULL) - ramp;
		if (32'(t) >= (32'(BLINK_WRAP) << cfg_blink))
			t = '0;
		lamp_timer[n] = t;
		return level[ALPHA_W-1:0];
	endfunction

	// Hold at full brightness, fade linearly, then stay dark with the timer frozen.
	function automatic logic [ALPHA_W-1:0] fade_step(input logic n);
		logic [31:0] t;
		logic [31:0] fade_end;
		logic [31:0] level;
		t = 32'(lamp_timer[n]);
		fade_end = 32'(cfg_hold) + (32'(FADE_STEPS) << cfg_fade);
		if (t < 32'(cfg_hold)) begin
			lamp_timer[n] = lamp_timer[n] + 1'b1;
			return ALPHA_FULL;
		end
		if (t < fade_end) begin
			t = t + 1;
			lamp_timer[n] = t[TIMER_W-1:0];
			level = 32'(ALPHA_FULL) - ((t - 32'(cfg_hold)) >> cfg_fade);
			return level[ALPHA_W-1:0];
		end
		return ALPHA_DARK;
	endfunction

	function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] c,
			input logic [ALPHA_W-1:0] a);
		logic [15:0] p;
		p = 16'(c) * 16'(a);
		return p[15:8];
	endfunction

	// Apply one accepted word to the shadow state; returns 1 when a drive word follows.
	function automatic bit predict_drive(input item_t w, output drive_t d);
		logic [ALPHA_W-1:0] a;
		d = '0;
		if (w.func == FUNC_LOAD) begin
			lamp_red[w.led_select]   = w.red;
			lamp_green[w.led_select] = w.green;
			lamp_blue[w.led_select]  = w.blue;
			if (!(lamp_mode[w.led_select] == MODE_BLINK && w.mode == MODE_BLINK))
				lamp_timer[w.led_select] = '0;
			lamp_mode[w.led_select] = w.mode;
			return 1'b0;
		end
		serve_turn = ~serve_turn;
		case (lamp_mode[serve_turn])
			MODE_BLINK:   a = blink_step(serve_turn);
			MODE_TIMEOUT: a = fade_step(serve_turn);
			default:      a = ALPHA_FULL;
		endcase
		d.led   = serve_turn;
		d.alpha = a;
		d.red   = scale_color(lamp_red[serve_turn], a);
		d.green = scale_color(lamp_green[serve_turn], a);
		d.blue  = scale_color(lamp_blue[serve_turn], a);
		return 1'b1;
	endfunction

	function automatic item_t random_word(input int load_pct);
		item_t w;
		w.func       = ($urandom_range(0, 99) < load_pct) ? FUNC_LOAD : FUNC_TICK;
		w.led_select = 1'($urandom_range(0, 1));
		w.red        = 8'($urandom_range(0, 255));
		w.green      = 8'($urandom_range(0, 255));
		w.blue       = 8'($urandom_range(0, 255));
		w.mode       = mode_t'($urandom_range(0, 3));
		return w;
	endfunction

	function automatic item_t tick_word();
		return random_word(0);
	endfunction

	function automatic item_t load_word(input logic sel, input logic [COLOR_W-1:0] r,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b, input mode_t m);
		item_t w;
		w.func       = FUNC_LOAD;
		w.led_select = sel;
		w.red        = r;
		w.green      = g;
		w.blue       = b;
		w.mode       = m;
		return w;
	endfunction

	// Offer one word after a random gap and wait until it is taken.
	task automatic send_word(input item_t w);
		drive_t d;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid      <= 1'b1;
		item_bus.func       <= w.func;
		item_bus.led_select <= w.led_select;
		item_bus.red_in     <= w.red;
		item_bus.green_in   <= w.green;
		item_bus.blue_in    <= w.blue;
		item_bus.mode_in    <= w.mode;
		do @(posedge clk); while (!item_bus.ready);
		if (predict_drive(w, d))
			expected_drives.push_back(d);
	endtask

	// Write one register; the caller lowers valid after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DAT_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (index)
			REG_HOLD_TICKS:  cfg_hold  = value;
			REG_BLINK_SHIFT: cfg_blink = value[SHIFT_W-1:0];
			REG_FADE_SHIFT:  cfg_fade  = value[SHIFT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [HOLD_W-1:0] hold,
			input logic [SHIFT_W-1:0] blink, input logic [SHIFT_W-1:0] fade);
		write_reg(REG_HOLD_TICKS, hold);
		write_reg(REG_BLINK_SHIFT, CFG_DAT_W'(blink));
		write_reg(REG_FADE_SHIFT, CFG_DAT_W'(fade));
		cfg_bus.valid <= 1'b0;
	endtask

	// Let every outstanding drive word arrive, then let loads in flight settle.
	task automatic wait_quiet();
		int waited = 0;
		item_bus.valid <= 1'b0;
		while (expected_drives.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_drives.size() != 0) begin
			$error("%0d expected drive words never arrived", expected_drives.size());
			fail_count++;
			expected_drives.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			fail_count++;
		end
	endtask

	// Out of reset both LEDs hold full brightness on color 100.
	task automatic test_reset_state();
		repeat (4) send_word(tick_word());
	endtask

	// Every mode, the unused code, blink reloaded as blink, and color extremes.
	task automatic test_modes();
		send_word(load_word(1'b1, 8'hFF, 8'h00, 8'hFF, MODE_BLINK));
		send_word(load_word(1'b0, 8'h00, 8'hFF, 8'h00, MODE_CONST));
		repeat (4) send_word(tick_word());
		send_word(load_word(1'b1, 8'h01, 8'h80, 8'hFE, MODE_BLINK));
		repeat (2) send_word(tick_word());
		send_word(load_word(1'b0, 8'hFF, 8'hFF, 8'hFF, MODE_CONST_ALT));
		send_word(load_word(1'b1, 8'h80, 8'h40, 8'h20, MODE_TIMEOUT));
		repeat (2) send_word(tick_word());
		send_word(load_word(1'b1, 8'hFF, 8'hFF, 8'hFF, MODE_CONST));
		repeat (2) send_word(tick_word());
	endtask

	// Fastest settings: LED 0 blinks through a full wave and wraps, LED 1 fades out.
	task automatic test_long_blink_and_fade();
		wait_quiet();
		write_settings(24'd3, 3'd0, 3'd0);
		send_word(load_word(1'b0, 8'hFF, 8'h80, 8'h01, MODE_BLINK));
		send_word(load_word(1'b1, 8'hFF, 8'hFF, 8'hFF, MODE_TIMEOUT));
		repeat (1060) begin
			if ($urandom_range(0, 49) == 0)
				send_word(load_word(1'b0, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					MODE_BLINK));
			else
				send_word(tick_word());
		end
	endtask

	// Timers keep running while the hold and shift registers change under them.
	task automatic test_register_change_midway();
		wait_quiet();
		write_settings(24'd40, 3'd2, 3'd1);
		send_word(load_word(1'b0, 8'hC0, 8'h30, 8'hFF, MODE_BLINK));
		send_word(load_word(1'b1, 8'hFF, 8'h7F, 8'h10, MODE_TIMEOUT));
		repeat (40) send_word(tick_word());
		wait_quiet();
		write_settings(24'd5, 3'd0, 3'd2);
		repeat (20) send_word(tick_word());
		wait_quiet();
		write_settings(24'd300, 3'd5, 3'd0);
		repeat (16) send_word(tick_word());
	endtask

	// The result side holds off for a long stretch so the block fills and stalls input.
	task automatic test_output_hold_off();
		src_idle_pct = 0;
		hold_off_go <= ~hold_off_go;
		repeat (40) send_word(random_word(10));
	endtask

	// Random words under each idling pattern, with a new register setting per phase.
	task automatic test_random_traffic();
		int src_pct [4]  = '{0, 74, 0, 21};
		int sink_pct [4] = '{0, 0, 74, 21};
		for (int p = 0; p < 4; p++) begin
			wait_quiet();
			case (p)
				0: write_settings(24'd0, 3'd0, 3'd0);
				1: write_settings(24'hFFFFFF, 3'd7, 3'd7);
				2: write_settings(24'($urandom_range(0, 400)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)));
				default: write_settings(24'($urandom_range(0, 60)),
					3'($urandom_range(0, 3)), 3'($urandom_range(0, 2)));
			endcase
			src_idle_pct = src_pct[p];
			sink_stall_pct <= sink_pct[p];
			repeat (RANDOM_PER_PHASE) send_word(random_word(12));
		end
	endtask

	// Result ready: random stalls, plus a counted hold-off on request.
	initial begin
		int   stall_left;
		logic seen;
		stall_left = 0;
		seen = 1'b0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go != seen) begin
				seen = hold_off_go;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// Compare each taken drive word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_drives.size() == 0) begin
				$error("drive word with no expectation: led %0d alpha %0d",
					result_bus.led_served, result_bus.alpha_out);
				fail_count++;
			end else begin
				due_drive = expected_drives.pop_front();
				check_field("led_served", 32'(due_drive.led), 32'(result_bus.led_served));
				check_field("alpha_out", 32'(due_drive.alpha), 32'(result_bus.alpha_out));
				check_field("red_drive", 32'(due_drive.red), 32'(result_bus.red_drive));
				check_field("green_drive", 32'(due_drive.green),
					32'(result_bus.green_drive));
				check_field("blue_drive", 32'(due_drive.blue), 32'(result_bus.blue_drive));
			end
		end
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		item_bus.valid      <= 1'b0;
		item_bus.func       <= FUNC_TICK;
		item_bus.led_select <= 1'b0;
		item_bus.red_in     <= '0;
		item_bus.green_in   <= '0;
		item_bus.blue_in    <= '0;
		item_bus.mode_in    <= MODE_CONST;
		cfg_bus.valid       <= 1'b0;
		cfg_bus.index       <= REG_HOLD_TICKS;
		cfg_bus.data        <= '0;
		cfg_hold   = HOLD_TICKS_RST;
		cfg_blink  = BLINK_SHIFT_RST;
		cfg_fade   = FADE_SHIFT_RST;
		serve_turn = 1'b0;
		for (int i = 0; i < LED_COUNT; i++) begin
			lamp_timer[i] = '0;
			lamp_mode[i]  = MODE_TIMEOUT;
			lamp_red[i]   = COLOR_RST;
			lamp_green[i] = COLOR_RST;
			lamp_blue[i]  = COLOR_RST;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_modes();
		test_long_blink_and_fade();
		test_register_change_midway();
		test_output_hold_off();
		test_random_traffic();
		wait_quiet();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/rgbseq_pkg.sv
hw/rtl/rgbseq_item_if.sv
hw/rtl/rgbseq_result_if.sv
hw/rtl/rgbseq_cfg_if.sv
hw/rtl/rgbseq_led_core.sv
hw/rtl/rgbseq_drive_stage.sv
hw/rtl/rgb_led_blink_fade_sequencer_unit.sv
sim/rgb_led_blink_fade_sequencer_unit_tb.sv
